// File: rtl/core/apc_pkg.sv
// Shared types, codes and widths for the arm position PWM controller.
package apc_pkg;

   // Position and switch geometry.
   localparam int POS_WIDTH    = 24;
   localparam int NUM_SWITCHES = 4;

   // Field widths.
   localparam int CMD_WIDTH    = 2;
   localparam int GAIN_WIDTH   = 9;
   localparam int DUTY_WIDTH   = 8;
   localparam int DB_WIDTH     = 16;
   localparam int ZONE_WIDTH   = 16;
   localparam int TRAVEL_WIDTH = 23;
   localparam int DIR_WIDTH    = 2;
   localparam int CSR_IDX_WIDTH  = 3;
   localparam int CSR_DATA_WIDTH = 23;

   // Divider sizes: the dividend is duty times a distance below the zone length.
   localparam int DIVIDEND_WIDTH = DUTY_WIDTH + ZONE_WIDTH;
   localparam int DIVISOR_WIDTH  = ZONE_WIDTH;

   // Stream payload widths.
   localparam int REQ_DATA_WIDTH = 64;
   localparam int RSP_DATA_WIDTH = 24;

   // Full-scale gain in Q8.
   localparam logic [GAIN_WIDTH-1:0] GAIN_FULL = 9'd256;

   // Configuration register indexes.
   typedef enum logic [CSR_IDX_WIDTH-1:0] {
      CSR_DEADBAND   = 3'd0,
      CSR_PWM_TOP    = 3'd1,
      CSR_SOFT_ZONE  = 3'd2,
      CSR_TRAVEL_END = 3'd3,
      CSR_DEBOUNCE   = 3'd4
   } csr_index_type;

   // Command codes.
   typedef enum logic [CMD_WIDTH-1:0] {
      CMD_TICK  = 2'd0,
      CMD_START = 2'd1,
      CMD_MOVE  = 2'd2,
      CMD_HOME  = 2'd3
   } cmd_type;

   // Motion direction codes.
   typedef enum logic [DIR_WIDTH-1:0] {
      DIR_HOLD    = 2'd0,
      DIR_FORWARD = 2'd1,
      DIR_REVERSE = 2'd2
   } dir_type;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SCALE,
      ST_PROD,
      ST_DIVGO,
      ST_WAIT,
      ST_FIN
   } state_type;

endpackage

// File: rtl/core/apc_div.sv
// Restoring divider that produces one quotient bit per cycle.
module apc_div (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   input  logic [apc_pkg::DIVIDEND_WIDTH-1:0]     dividend,
   input  logic [apc_pkg::DIVISOR_WIDTH-1:0]      divisor,
   output logic                                   done,
   output logic [apc_pkg::DIVIDEND_WIDTH-1:0]     quotient
);

   localparam int NW = apc_pkg::DIVIDEND_WIDTH;
   localparam int DW = apc_pkg::DIVISOR_WIDTH;
   localparam int CW = $clog2(NW);
   localparam logic [CW-1:0] LAST_STEP = CW'(NW - 1);

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [DW-1:0] rem_ff, rem_in;
   logic [NW-1:0] quo_ff, quo_in;
   logic [DW-1:0] div_ff, div_in;

   logic [DW:0]   shifted;
   logic [DW:0]   trial;
   logic          fits;

   // One trial subtraction of the shifted remainder.
   assign shifted = {rem_ff, quo_ff[NW-1]};
   assign trial   = shifted - {1'b0, div_ff};
   assign fits    = shifted >= {1'b0, div_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      div_in  = div_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = dividend;
         div_in  = divisor;
      end else if (busy_ff) begin
         rem_in = fits ? trial[DW-1:0] : shifted[DW-1:0];
         quo_in = {quo_ff[NW-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control state is reset; the datapath registers are not.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      div_ff <= div_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// File: rtl/core/arm_position_pwm_controller.sv
// Top level of the arm position controller with PWM drive and limit switches.
//
// Each command transfer produces one result transfer. A start, move or homing command
// passes the execute and finish states before the next command can be taken, and a
// tick the execute, scale and finish states. When the duty tapers near a travel end, a
// tick also waits for the taper scale from a restoring divider that resolves one of
// its 24 quotient bits per cycle. The block takes one command at a time and accepts the
// next one while a finished result still waits on the result channel. Configuration
// writes are taken at any time and should be made only while no command is in flight.
module arm_position_pwm_controller (
   input  logic                                   clock,
   input  logic                                   reset,
   // Command channel.
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   // encoder_position[23:0], target_or_delta[47:24], duty_gain[56:48],
   // limit_sw1[57], limit_sw2[58], limit_sw3[59], limit_sw4[60], zero fill.
   input  logic [apc_pkg::REQ_DATA_WIDTH-1:0]     req_tdata,
   // cmd[1:0].
   input  logic [apc_pkg::CMD_WIDTH-1:0]          req_tuser,
   // Result channel.
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   // drive_enable[0], drive_line[1], status_leds[5:2], encoder_clear[6], running[7],
   // direction[9:8], duty[17:10], zero fill.
   output logic [apc_pkg::RSP_DATA_WIDTH-1:0]     rsp_tdata,
   // Configuration write port.
   input  logic                                   csr_we,
   input  logic [apc_pkg::CSR_IDX_WIDTH-1:0]      csr_index,
   input  logic [apc_pkg::CSR_DATA_WIDTH-1:0]     csr_wdata
);

   localparam int PW = apc_pkg::POS_WIDTH;
   localparam int NS = apc_pkg::NUM_SWITCHES;
   localparam int DTW = apc_pkg::DUTY_WIDTH;
   localparam int ZW = apc_pkg::ZONE_WIDTH;
   localparam int GW = apc_pkg::GAIN_WIDTH;
   localparam int EW = PW + 2;               // wide signed width for compares
   localparam logic [DTW-1:0] CNT_MAX = '1;
   localparam logic signed [PW-1:0] POS_MAX = {1'b0, {(PW-1){1'b1}}};
   localparam logic signed [PW-1:0] POS_MIN = {1'b1, {(PW-1){1'b0}}};

   // ------------------------------------------------------------------
   // Configuration registers.
   logic [apc_pkg::DB_WIDTH-1:0]     deadband_ff;
   logic [DTW-1:0]                   pwm_top_ff;
   logic [ZW-1:0]                    soft_zone_ff;
   logic [apc_pkg::TRAVEL_WIDTH-1:0] travel_end_ff;
   logic [DTW-1:0]                   debounce_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         deadband_ff   <= 16'd500;
         pwm_top_ff    <= 8'd100;
         soft_zone_ff  <= 16'd3000;
         travel_end_ff <= 23'd80000;
         debounce_ff   <= 8'd100;
      end else if (csr_we) begin
         case (csr_index)
            apc_pkg::CSR_DEADBAND:   deadband_ff   <= csr_wdata[apc_pkg::DB_WIDTH-1:0];
            apc_pkg::CSR_PWM_TOP:    pwm_top_ff    <= csr_wdata[DTW-1:0];
            apc_pkg::CSR_SOFT_ZONE:  soft_zone_ff  <= csr_wdata[ZW-1:0];
            apc_pkg::CSR_TRAVEL_END: travel_end_ff <= csr_wdata;
            apc_pkg::CSR_DEBOUNCE:   debounce_ff   <= csr_wdata[DTW-1:0];
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------------------
   // Captured command fields.
   apc_pkg::cmd_type          cmd_ff;
   logic signed [PW-1:0]      pos_ff;
   logic signed [PW-1:0]      tod_ff;
   logic [GW-1:0]             gain_in_ff;
   logic [NS-1:0]             sw_ff;

   // ------------------------------------------------------------------
   // Sequencer.
   apc_pkg::state_type    state_ff, state_in;
   logic                  div_start;
   logic                  div_done;
   logic                  taper_ff;
   logic [apc_pkg::DIVIDEND_WIDTH-1:0] quotient;

   logic req_xfer;
   logic rsp_xfer_ok;

   assign req_xfer    = req_tvalid && req_tready;
   assign rsp_xfer_ok = !rsp_tvalid || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= apc_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      div_start  = 1'b0;
      case (state_ff)
         apc_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) state_in = apc_pkg::ST_EXEC;
         end
         apc_pkg::ST_EXEC: begin
            state_in = (cmd_ff == apc_pkg::CMD_TICK) ? apc_pkg::ST_SCALE : apc_pkg::ST_FIN;
         end
         apc_pkg::ST_SCALE: begin
            state_in = taper_ff ? apc_pkg::ST_PROD : apc_pkg::ST_FIN;
         end
         apc_pkg::ST_PROD: begin
            state_in = (soft_zone_ff == '0) ? apc_pkg::ST_FIN : apc_pkg::ST_DIVGO;
         end
         apc_pkg::ST_DIVGO: begin
            div_start = 1'b1;
            state_in  = apc_pkg::ST_WAIT;
         end
         apc_pkg::ST_WAIT: begin
            if (div_done) state_in = apc_pkg::ST_FIN;
         end
         apc_pkg::ST_FIN: begin
            if (rsp_xfer_ok) state_in = apc_pkg::ST_IDLE;
         end
         default: state_in = apc_pkg::ST_IDLE;
      endcase
   end

   // Command fields are captured at the transfer.
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         cmd_ff     <= apc_pkg::cmd_type'(req_tuser);
         pos_ff     <= req_tdata[PW-1:0];
         tod_ff     <= req_tdata[2*PW-1:PW];
         gain_in_ff <= req_tdata[2*PW+GW-1:2*PW];
         sw_ff      <= req_tdata[2*PW+GW+NS-1:2*PW+GW];
      end
   end

   // ------------------------------------------------------------------
   // Controller state.
   logic [DTW-1:0]        phase_ff;
   apc_pkg::dir_type      dir_ff;
   logic [DTW-1:0]        duty_ff;
   logic                  run_ff;
   logic                  homing_ff;
   logic signed [PW-1:0]  target_ff;
   logic [GW-1:0]         gain_ff;
   logic [DTW-1:0]        sw_cnt_ff [NS];
   logic                  line_en_ff;
   logic                  line_dr_ff;
   logic                  clr_ff;

   // Registered intermediate values of a tick.
   logic [DTW-1:0]        base_ff;
   logic [ZW-1:0]         dist_ff;
   logic [apc_pkg::DIVIDEND_WIDTH-1:0] prod_ff;

   // Phase step and held-line drive.
   logic [DTW:0]          phase_inc;
   logic [DTW-1:0]        phase_new;
   logic                  drive_on;

   assign phase_inc = {1'b0, phase_ff} + 1'b1;
   assign phase_new = (phase_inc > {1'b0, pwm_top_ff}) ? '0 : phase_inc[DTW-1:0];
   assign drive_on  = run_ff && (duty_ff > phase_new);

   // Position error against the deadband.
   logic signed [EW-1:0]  pos_w, tgt_w, err_w, db_w, zone_w, far_w, far_dist_w;
   logic                  go_fwd, go_rev;
   logic [PW:0]           err_abs;
   logic [PW-1:0]         half_err;
   logic [DTW-1:0]        base_new;
   apc_pkg::dir_type      dir_new;

   assign pos_w      = EW'(pos_ff);
   assign tgt_w      = EW'(target_ff);
   assign err_w      = pos_w - tgt_w;
   assign db_w       = $signed({{(EW-apc_pkg::DB_WIDTH){1'b0}}, deadband_ff});
   assign zone_w     = $signed({{(EW-ZW){1'b0}}, soft_zone_ff});
   assign far_w      = $signed({{(EW-apc_pkg::TRAVEL_WIDTH){1'b0}}, travel_end_ff});
   assign far_dist_w = far_w - pos_w;
   assign go_fwd     = err_w < -db_w;
   assign go_rev     = err_w > db_w;
   assign err_abs    = err_w[EW-1] ? -err_w[PW:0] : err_w[PW:0];
   assign half_err   = err_abs[PW:1];
   assign base_new   = (half_err < PW'(pwm_top_ff)) ? half_err[DTW-1:0] : pwm_top_ff;

   always_comb begin
      if (go_fwd) begin
         dir_new = apc_pkg::DIR_FORWARD;
      end else if (go_rev) begin
         dir_new = apc_pkg::DIR_REVERSE;
      end else begin
         dir_new = apc_pkg::DIR_HOLD;
      end
   end

   // Taper selection near either travel end.
   logic taper_home, taper_far;
   logic [ZW-1:0] dist_new;

   assign taper_home = !homing_ff && (dir_new != apc_pkg::DIR_FORWARD) && (pos_w < zone_w);
   assign taper_far  = !taper_home && !homing_ff && (dir_new != apc_pkg::DIR_REVERSE) &&
                       (pos_w > far_w - zone_w);

   always_comb begin
      if (taper_home) begin
         dist_new = pos_w[EW-1] ? '0 : pos_w[ZW-1:0];
      end else begin
         dist_new = far_dist_w[EW-1] ? '0 : far_dist_w[ZW-1:0];
      end
   end

   // Switch debounce.
   logic [DTW-1:0] thr;
   logic [DTW-1:0] sw_cnt_new [NS];
   logic [NS-1:0]  pressed;
   logic [NS-1:0]  leds_now;

   assign thr = (debounce_ff == '0) ? DTW'(1) : debounce_ff;

   always_comb begin
      for (int i = 0; i < NS; i++) begin
         if (sw_ff[i]) begin
            sw_cnt_new[i] = (sw_cnt_ff[i] == CNT_MAX) ? CNT_MAX : sw_cnt_ff[i] + 1'b1;
         end else begin
            sw_cnt_new[i] = '0;
         end
         pressed[i]  = sw_ff[i] && (sw_cnt_new[i] >= thr);
         leds_now[i] = sw_cnt_ff[i] >= thr;
      end
   end

   // Target and gain update for start, move and homing commands.
   logic signed [PW:0]   move_sum;
   logic signed [PW-1:0] move_sat;
   logic [GW-1:0]        gain_sat;

   assign move_sum = (PW+1)'(target_ff) + (PW+1)'(tod_ff);
   always_comb begin
      if (move_sum[PW] != move_sum[PW-1]) begin
         move_sat = move_sum[PW] ? POS_MIN : POS_MAX;
      end else begin
         move_sat = move_sum[PW-1:0];
      end
   end
   assign gain_sat = (gain_in_ff > apc_pkg::GAIN_FULL) ? apc_pkg::GAIN_FULL : gain_in_ff;

   // Scaled duty before any taper.
   logic [DTW+GW-1:0] scaled;
   assign scaled = {{GW{1'b0}}, base_ff} * {{DTW{1'b0}}, gain_ff};

   // Control state updates.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= '0;
         dir_ff     <= apc_pkg::DIR_HOLD;
         duty_ff    <= '0;
         run_ff     <= 1'b0;
         homing_ff  <= 1'b1;
         target_ff  <= '0;
         gain_ff    <= '0;
         line_en_ff <= 1'b0;
         line_dr_ff <= 1'b0;
         clr_ff     <= 1'b0;
         taper_ff   <= 1'b0;
         for (int i = 0; i < NS; i++) sw_cnt_ff[i] <= '0;
      end else begin
         case (state_ff)
            apc_pkg::ST_EXEC: begin
               case (cmd_ff)
                  apc_pkg::CMD_START, apc_pkg::CMD_HOME: begin
                     target_ff <= tod_ff;
                     gain_ff   <= gain_sat;
                     run_ff    <= 1'b1;
                     clr_ff    <= 1'b0;
                     if (cmd_ff == apc_pkg::CMD_HOME) homing_ff <= 1'b1;
                  end
                  apc_pkg::CMD_MOVE: begin
                     target_ff <= move_sat;
                     gain_ff   <= gain_sat;
                     run_ff    <= 1'b1;
                     clr_ff    <= 1'b0;
                  end
                  default: begin
                     // Tick: step the phase and drive from the held values.
                     phase_ff <= phase_new;
                     dir_ff   <= dir_new;
                     taper_ff <= taper_home || taper_far;
                     for (int i = 0; i < NS; i++) sw_cnt_ff[i] <= sw_cnt_new[i];
                     run_ff   <= run_ff && (dir_new != apc_pkg::DIR_HOLD) && (pressed == '0);
                     clr_ff   <= pressed[0];
                     if (pressed[0]) begin
                        homing_ff  <= 1'b0;
                        line_en_ff <= 1'b1;
                        line_dr_ff <= 1'b1;
                     end else if (pressed[1]) begin
                        line_en_ff <= 1'b0;
                        line_dr_ff <= 1'b1;
                     end else begin
                        line_en_ff <= drive_on && (dir_ff == apc_pkg::DIR_FORWARD);
                        line_dr_ff <= drive_on && (dir_ff != apc_pkg::DIR_HOLD);
                     end
                  end
               endcase
            end
            apc_pkg::ST_SCALE: duty_ff <= scaled[DTW+7:8];
            apc_pkg::ST_PROD: begin
               if (soft_zone_ff == '0) duty_ff <= '0;
            end
            apc_pkg::ST_WAIT: begin
               if (div_done) duty_ff <= quotient[DTW-1:0];
            end
            default: ;
         endcase
      end
   end

   // Tick datapath registers.
   always_ff @(posedge clock) begin
      if (state_ff == apc_pkg::ST_EXEC) begin
         base_ff <= base_new;
         dist_ff <= dist_new;
      end
      if (state_ff == apc_pkg::ST_PROD) begin
         prod_ff <= {{ZW{1'b0}}, duty_ff} * {{DTW{1'b0}}, dist_ff};
      end
   end

   // Divider for the taper scale.
   apc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (prod_ff),
      .divisor  (soft_zone_ff),
      .done     (div_done),
      .quotient (quotient)
   );

   // ------------------------------------------------------------------
   // Result register: loaded when the sequencer finishes and the slot is free.
   logic                               rsp_valid_ff;
   logic [apc_pkg::RSP_DATA_WIDTH-1:0] rsp_data_ff;
   logic [3:0]                         leds_out;

   assign leds_out = 4'(leds_now);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if ((state_ff == apc_pkg::ST_FIN) && rsp_xfer_ok) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if ((state_ff == apc_pkg::ST_FIN) && rsp_xfer_ok) begin
         rsp_data_ff <= {6'd0, duty_ff, dir_ff, run_ff, clr_ff, leds_out,
                         line_dr_ff, line_en_ff};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // ------------------------------------------------------------------
   // Assertions.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> !req_tready)
      else $error("command accepted while a previous one is in work");

   a_clear_needs_led: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (!rsp_tdata[6] || rsp_tdata[2]))
      else $error("encoder clear without the home switch pressed");

   a_div_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == apc_pkg::ST_WAIT))
      else $error("divider finished outside the wait state");

   a_div_only_on_taper: assert property (@(posedge clock) disable iff (reset)
      div_start |-> (taper_ff && (soft_zone_ff != '0)))
      else $error("divider started without a taper");

endmodule
